[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// immediate-implication and next-cycle-implication checks for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

[rtl/trm_pkg.sv]
// ----------------------------------------------------------------------------
// trm_pkg
// shared constants, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package trm_pkg;

    // default build parameters
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int MAX_WINDOW_DEF  = 4096;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_LEN_W   = 13;
    localparam int CFG_AVG_W   = 8;
    localparam int CFG_SCALE_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_WINDOWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAINS_SCALE = 2'd2;

    localparam logic [CFG_LEN_W-1:0]   WINDOW_LEN_RST  = 13'd256;
    localparam logic [CFG_AVG_W-1:0]   AVG_WINDOWS_RST = 8'd1;
    localparam logic [CFG_SCALE_W-1:0] MAINS_SCALE_RST = 24'd65536;

    // result scaling
    localparam int MV_W     = 20;
    localparam int VSUM_W   = 28;
    localparam int MV_SHIFT = 24;   // q.8 rms times q8.16 gain
    localparam int SQ_FRAC  = 16;   // square sum scaled up before the divide
    localparam logic [MV_W-1:0] MV_MAX = 20'hFFFFF;

    // divider operand select
    typedef logic [1:0] t_div_sel;
    localparam t_div_sel DIV_MEAN = 2'd0;
    localparam t_div_sel DIV_SQ   = 2'd1;
    localparam t_div_sel DIV_AVG  = 2'd2;

    typedef struct packed {
        logic     accept;
        logic     acc_sq;
        logic     div_start;
        t_div_sel div_sel;
        logic     cal_end;
        logic     mean_latch;
        logic     sqrt_start;
        logic     mul;
        logic     rnd;
        logic     win_close;
        logic     avg_latch;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic win_end;
        logic grp_end;
        logic calib;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_status;

endpackage

[rtl/trm_div.sv]
// ----------------------------------------------------------------------------
// trm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module trm_div #(
    parameter int DW = 53,
    parameter int VW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient,
    output logic          o_done
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_left;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          ge;

    assign shifted = {r_rem, r_q[DW-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign ge      = (shifted >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= CW'(DW);
            end else if (r_busy) begin
                r_left <= r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[VW-1:0] : shifted[VW-1:0];
            r_q   <= {r_q[DW-2:0], ge};
        end
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;

endmodule

[rtl/trm_sqrt.sv]
// ----------------------------------------------------------------------------
// trm_sqrt
// floored integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module trm_sqrt #(
    parameter int IN_W = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_radicand,
    output logic [IN_W/2-1:0] o_root,
    output logic              o_done
);

    localparam int K  = IN_W / 2;
    localparam int TW = K + 3;
    localparam int CW = $clog2(K + 1);

    logic [IN_W-1:0] r_x;
    logic [K:0]      r_rem;
    logic [K-1:0]    r_root;
    logic [CW-1:0]   r_left;
    logic            r_busy;
    logic            r_done;

    logic [TW-1:0]   trial;
    logic [TW-1:0]   test;
    logic [TW-1:0]   diff;
    logic            ge;

    // bring down the next two radicand bits and test root*4+1
    assign trial = {r_rem, r_x[IN_W-1 -: 2]};
    assign test  = TW'({r_root, 2'b01});
    assign diff  = trial - test;
    assign ge    = (trial >= test);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= CW'(K);
            end else if (r_busy) begin
                r_left <= r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[IN_W-3:0], 2'b00};
            r_rem  <= ge ? diff[K:0] : trial[K:0];
            r_root <= {r_root[K-2:0], ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

[rtl/trm_dp.sv]
// ----------------------------------------------------------------------------
// trm_dp
// datapath: configuration, window accumulators, shared divider, root,
// scaling and the result register
// ----------------------------------------------------------------------------
module trm_dp #(
    parameter int SAMPLE_BITS = 12,
    parameter int MAX_WINDOW  = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  trm_pkg::t_cmd                      i_cmd,
    output trm_pkg::t_status                   o_status,
    input  logic [SAMPLE_BITS-1:0]             i_sample,
    input  logic                               i_cfg_we,
    input  logic [trm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [trm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_result_valid,
    input  logic                               i_result_ready,
    output logic [trm_pkg::MV_W-1:0]           o_voltage_mv,
    output logic [SAMPLE_BITS-1:0]             o_zero_level,
    output logic                               o_saturated
);

    import trm_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int LC_W   = (CNT_W > CFG_LEN_W) ? CNT_W : CFG_LEN_W;
    localparam int LV_W   = SB + CNT_W;
    localparam int SQ_W   = 2 * SB + CNT_W;
    localparam int DIV_W  = SQ_W + SQ_FRAC;
    localparam int DVS_W  = (CNT_W > CFG_AVG_W) ? CNT_W : CFG_AVG_W;
    localparam int RQ_W   = 2 * SB + SQ_FRAC;
    localparam int RMS_W  = RQ_W / 2;
    localparam int PROD_W = RMS_W + CFG_SCALE_W;
    localparam int MVF_W  = PROD_W + 1 - MV_SHIFT;
    localparam int CMP_W  = (MVF_W > MV_W) ? MVF_W : MV_W;

    // configuration
    logic [CFG_LEN_W-1:0]   r_len;
    logic [CFG_AVG_W-1:0]   r_avgw;
    logic [CFG_SCALE_W-1:0] r_scale;

    // window and group state
    logic [SB-1:0]        r_zero;
    logic [SB-1:0]        r_off;
    logic                 r_calib;
    logic [CNT_W-1:0]     r_cnt;
    logic [SQ_W-1:0]      r_sq;
    logic [LV_W-1:0]      r_level;
    logic [CFG_AVG_W-1:0] r_wc;
    logic [VSUM_W-1:0]    r_vsum;
    logic                 r_sat_seen;
    logic                 r_out_valid;

    // payload
    logic [SB-1:0]     r_d;
    logic [SB-1:0]     r_zero_new;
    logic [PROD_W-1:0] r_prod;
    logic [MV_W-1:0]   r_mv;
    logic              r_mv_sat;
    logic [MV_W-1:0]   r_avg;
    logic [MV_W-1:0]   r_out_mv;
    logic [SB-1:0]     r_out_zero;
    logic              r_out_sat;

    logic                 win_start;
    logic [SB-1:0]        off_eff;
    logic [LC_W-1:0]      len_ext;
    logic [CNT_W-1:0]     len_eff;
    logic [CFG_AVG_W-1:0] navg_eff;
    logic [2*SB-1:0]      sq_term;
    logic [DIV_W-1:0]     div_dvd;
    logic [DVS_W-1:0]     div_dvs;
    logic [DIV_W-1:0]     div_q;
    logic                 div_done;
    logic [RMS_W-1:0]     root;
    logic                 sqrt_done;
    logic [PROD_W:0]      rnd_sum;
    logic [MVF_W-1:0]     mv_full;
    logic [VSUM_W-1:0]    avg_dvd;

    // zero level is latched on the first sample of each window
    assign win_start = (r_cnt == '0);
    assign off_eff   = win_start ? r_zero : r_off;

    // effective limits: zero length acts as one, long windows are capped
    assign len_ext = LC_W'(r_len);
    always_comb begin
        if (r_len == '0) begin
            len_eff = CNT_W'(1);
        end else if (len_ext > LC_W'(MAX_WINDOW)) begin
            len_eff = CNT_W'(MAX_WINDOW);
        end else begin
            len_eff = CNT_W'(len_ext);
        end
    end
    assign navg_eff = (r_avgw == '0) ? CFG_AVG_W'(1) : r_avgw;

    assign sq_term = r_d * r_d;
    assign avg_dvd = r_vsum + VSUM_W'(r_wc >> 1);

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_MEAN: begin
                div_dvd = DIV_W'(r_level);
                div_dvs = DVS_W'(r_cnt);
            end
            DIV_SQ: begin
                div_dvd = {r_sq, {SQ_FRAC{1'b0}}};
                div_dvs = DVS_W'(r_cnt);
            end
            DIV_AVG: begin
                div_dvd = DIV_W'(avg_dvd);
                div_dvs = DVS_W'(r_wc);
            end
            default: begin
                div_dvd = DIV_W'(r_level);
                div_dvs = DVS_W'(r_cnt);
            end
        endcase
    end

    trm_div #(
        .DW (DIV_W),
        .VW (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    trm_sqrt #(
        .IN_W (RQ_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (div_q[RQ_W-1:0]),
        .o_root     (root),
        .o_done     (sqrt_done)
    );

    // round half up to millivolts
    assign rnd_sum = {1'b0, r_prod} + ((PROD_W + 1)'(1) << (MV_SHIFT - 1));
    assign mv_full = rnd_sum[PROD_W:MV_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= WINDOW_LEN_RST;
            r_avgw      <= AVG_WINDOWS_RST;
            r_scale     <= MAINS_SCALE_RST;
            r_zero      <= '0;
            r_off       <= '0;
            r_calib     <= 1'b0;
            r_cnt       <= '0;
            r_sq        <= '0;
            r_level     <= '0;
            r_wc        <= '0;
            r_vsum      <= '0;
            r_sat_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW_LEN:  r_len   <= i_cfg_data[CFG_LEN_W-1:0];
                    CFG_AVG_WINDOWS: r_avgw  <= i_cfg_data[CFG_AVG_W-1:0];
                    CFG_MAINS_SCALE: r_scale <= i_cfg_data[CFG_SCALE_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.accept) begin
                r_off   <= off_eff;
                r_calib <= win_start ? (r_zero == '0) : r_calib;
                r_level <= r_level + LV_W'(i_sample);
                r_cnt   <= r_cnt + CNT_W'(1);
            end

            if (i_cmd.acc_sq && !r_calib) begin
                r_sq <= r_sq + SQ_W'(sq_term);
            end

            if (i_cmd.cal_end) begin
                r_zero  <= div_q[SB-1:0];
                r_calib <= 1'b0;
                r_cnt   <= '0;
                r_sq    <= '0;
                r_level <= '0;
            end

            if (i_cmd.win_close) begin
                r_zero     <= r_zero_new;
                r_vsum     <= r_vsum + VSUM_W'(r_mv);
                r_wc       <= r_wc + CFG_AVG_W'(1);
                r_sat_seen <= r_sat_seen | r_mv_sat;
                r_cnt      <= '0;
                r_sq       <= '0;
                r_level    <= '0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_wc        <= '0;
                r_vsum      <= '0;
                r_sat_seen  <= 1'b0;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_d <= (i_sample >= off_eff) ? (i_sample - off_eff) : (off_eff - i_sample);
        end
        if (i_cmd.mean_latch) begin
            r_zero_new <= div_q[SB-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= root * r_scale;
        end
        if (i_cmd.rnd) begin
            if (CMP_W'(mv_full) >= CMP_W'(MV_MAX)) begin
                r_mv     <= MV_MAX;
                r_mv_sat <= 1'b1;
            end else begin
                r_mv     <= MV_W'(mv_full);
                r_mv_sat <= 1'b0;
            end
        end
        if (i_cmd.avg_latch) begin
            r_avg <= (div_q > DIV_W'(MV_MAX)) ? MV_MAX : div_q[MV_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_mv   <= r_avg;
            r_out_zero <= r_zero;
            r_out_sat  <= r_sat_seen;
        end
    end

    assign o_status.win_end   = (r_cnt >= len_eff);
    assign o_status.grp_end   = (r_wc >= navg_eff);
    assign o_status.calib     = r_calib;
    assign o_status.div_done  = div_done;
    assign o_status.sqrt_done = sqrt_done;
    assign o_status.out_free  = !r_out_valid || i_result_ready;

    assign o_result_valid = r_out_valid;
    assign o_voltage_mv   = r_out_mv;
    assign o_zero_level   = r_out_zero;
    assign o_saturated    = r_out_sat;

endmodule

[rtl/trm_ctrl.sv]
// ----------------------------------------------------------------------------
// trm_ctrl
// sequencer: sample accumulation, window-end arithmetic and result hand-off
// ----------------------------------------------------------------------------
module trm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_sample_valid,
    output logic             o_sample_ready,
    input  trm_pkg::t_status i_status,
    output trm_pkg::t_cmd    o_cmd
);

    import trm_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ACC       = 4'd1;
    localparam logic [3:0] S_MEAN_GO   = 4'd2;
    localparam logic [3:0] S_MEAN_WAIT = 4'd3;
    localparam logic [3:0] S_SQ_GO     = 4'd4;
    localparam logic [3:0] S_SQ_WAIT   = 4'd5;
    localparam logic [3:0] S_ROOT      = 4'd6;
    localparam logic [3:0] S_MUL       = 4'd7;
    localparam logic [3:0] S_RND       = 4'd8;
    localparam logic [3:0] S_WCLOSE    = 4'd9;
    localparam logic [3:0] S_GCHK      = 4'd10;
    localparam logic [3:0] S_AVG_GO    = 4'd11;
    localparam logic [3:0] S_AVG_WAIT  = 4'd12;
    localparam logic [3:0] S_EMIT      = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_sample_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_MEAN;
        unique case (r_state)
            S_IDLE: begin
                if (i_sample_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_sq = 1'b1;
                n_state = i_status.win_end ? S_MEAN_GO : S_IDLE;
            end
            S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MEAN;
                n_state = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_status.div_done) begin
                    if (i_status.calib) begin
                        o_cmd.cal_end = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.mean_latch = 1'b1;
                        n_state = S_SQ_GO;
                    end
                end
            end
            S_SQ_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SQ;
                n_state = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (i_status.sqrt_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state = S_WCLOSE;
            end
            S_WCLOSE: begin
                o_cmd.win_close = 1'b1;
                n_state = S_GCHK;
            end
            S_GCHK: begin
                n_state = i_status.grp_end ? S_AVG_GO : S_IDLE;
            end
            S_AVG_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_AVG;
                n_state = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.avg_latch = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/windowed_true_rms_meter_top.sv]
// ----------------------------------------------------------------------------
// windowed_true_rms_meter_top
// true-rms mains meter with tracked zero level, windowed and averaged.
// each sample transfer is accepted, then squared and accumulated before the
// next transfer. the last sample of a window starts two passes through the
// shared one-bit-per-cycle restoring divider, DW = 2*SAMPLE_BITS +
// clog2(MAX_WINDOW+1) + 16 bits wide (53 at defaults), for the window mean,
// then scaled square sum over count, and one pass of the one-bit-per-cycle
// root unit. a calibration window (zero level still 0) ends after the mean
// divide only. the last window of a group adds a third divider pass for the
// rounded average. samples are taken while a finished result waits in the
// output register; a new group result waits for that register to be freed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_true_rms_meter_top #(
    parameter int SAMPLE_BITS = trm_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW  = trm_pkg::MAX_WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample input channel
    input  logic                           i_sample_valid,
    output logic                           o_sample_ready,
    input  logic [SAMPLE_BITS-1:0]         i_sample,
    // result channel
    output logic                           o_result_valid,
    input  logic                           i_result_ready,
    output logic [trm_pkg::MV_W-1:0]       o_voltage_mv,
    output logic [SAMPLE_BITS-1:0]         o_zero_level,
    output logic                           o_saturated,
    // register write port
    input  logic                           i_cfg_we,
    input  logic [trm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [trm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import trm_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: owns the sample handshake and the window-end order
    trm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    // datapath: registers, accumulators, divider, root, scaling, output stage
    trm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_sample       (i_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_voltage_mv   (o_voltage_mv),
        .o_zero_level   (o_zero_level),
        .o_saturated    (o_saturated)
    );

    // after a transfer the next cycle is always the accumulate cycle
    `ASSERT_NEXT(a_accept_then_acc, i_clk, i_rst_n, cmd.accept, !o_sample_ready && cmd.acc_sq, "sample transfer not followed by accumulate")
    // a group result never overwrites one still waiting
    `ASSERT_IMPLIES(a_emit_free, i_clk, i_rst_n, cmd.emit, status.out_free, "result emitted over a waiting result")
    // closing a window restarts the sample count
    `ASSERT_NEXT(a_close_clears, i_clk, i_rst_n, cmd.win_close, !status.win_end, "window still ended after close")
    // an emitted result is presented in the following cycle
    `ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, cmd.emit, o_result_valid, "emitted result not presented")

endmodule

[dv/windowed_true_rms_meter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_true_rms_meter_top_tb
// self-checking bench for the windowed true-rms meter. a clocked driver feeds
// sample transfers from a backlog queue, a clocked monitor mirrors the meter
// in a cycle-free predictor and compares every reading field by field.
// phases change the register settings while the meter is quiet and vary the
// idling on both channels.
// ----------------------------------------------------------------------------
module windowed_true_rms_meter_top_tb;

    import trm_pkg::*;

    localparam int SB            = SAMPLE_BITS_DEF;
    localparam int MAX_WIN       = MAX_WINDOW_DEF;
    localparam int CLK_HALF      = 4;
    localparam int DRAIN_CYCLES  = 400;    // window end plus group average, with margin
    localparam int WATCHDOG_MAX  = 5000;   // cycles with no transfer at all
    localparam int REPORT_LIMIT  = 10;

    // no register sits behind this index, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic [SB-1:0]   zero;
        logic            sat;
    } t_reading;

    // dut ports, all inputs known from time zero
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_sample_valid = 1'b0;
    logic                  o_sample_ready;
    logic [SB-1:0]         i_sample       = '0;
    logic                  o_result_valid;
    logic                  i_result_ready = 1'b0;
    logic [MV_W-1:0]       o_voltage_mv;
    logic [SB-1:0]         o_zero_level;
    logic                  o_saturated;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    windowed_true_rms_meter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_voltage_mv   (o_voltage_mv),
        .o_zero_level   (o_zero_level),
        .o_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // bench bookkeeping
    logic [SB-1:0] sample_backlog [$];     // samples waiting for the driver
    t_reading      pending_readings [$];   // readings the meter still owes us
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            fail_count     = 0;
    int            quiet_cycles   = 0;
    logic          sample_taken   = 1'b0;

    // ------------------------------------------------------------------------
    // meter predictor: registers and running state
    // ------------------------------------------------------------------------
    logic [CFG_LEN_W-1:0]   win_len_q;
    logic [CFG_AVG_W-1:0]   avg_win_q;
    logic [CFG_SCALE_W-1:0] gain_q;

    logic [SB-1:0] zero_trk;
    logic [SB-1:0] win_zero;       // zero level latched at window start
    logic          calibrating;
    int unsigned   win_samples;
    logic [63:0]   dev_sq_acc;
    logic [63:0]   level_acc;
    int unsigned   grp_windows;
    logic [63:0]   mv_acc;
    logic          grp_sat;

    function automatic void meter_reset();
        win_len_q   = WINDOW_LEN_RST;
        avg_win_q   = AVG_WINDOWS_RST;
        gain_q      = MAINS_SCALE_RST;
        zero_trk    = '0;
        win_zero    = '0;
        calibrating = 1'b0;
        win_samples = 0;
        dev_sq_acc  = '0;
        level_acc   = '0;
        grp_windows = 0;
        mv_acc      = '0;
        grp_sat     = 1'b0;
    endfunction

    // floored integer square root, one result bit per pass
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] b;
        root = '0;
        rem  = v;
        b    = 64'h4000_0000_0000_0000;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // advances the meter by one sample, returns 1 when a group reading is due
    function automatic bit predict_meter_sample(input logic [SB-1:0] s, output t_reading rd);
        int unsigned len;
        int unsigned navg;
        logic [63:0] dev;
        logic [63:0] mean;
        logic [63:0] rms;
        logic [63:0] mv;
        logic [63:0] avg;
        rd   = '0;
        len  = win_len_q;
        navg = avg_win_q;
        // zero length acts as one, oversize lengths are clamped
        if (len == 0) len = 1;
        if (len > MAX_WIN) len = MAX_WIN;
        if (navg == 0) navg = 1;

        // window start: latch the zero level, calibrate while it is still unknown
        if (win_samples == 0) begin
            win_zero    = zero_trk;
            calibrating = (zero_trk == '0);
        end

        level_acc = level_acc + 64'(s);
        if (!calibrating) begin
            dev = (s >= win_zero) ? 64'(s) - 64'(win_zero) : 64'(win_zero) - 64'(s);
            dev_sq_acc = dev_sq_acc + dev * dev;
        end
        win_samples++;

        // a shortened length ends the window at once
        if (win_samples < len) return 1'b0;

        mean     = level_acc / 64'(win_samples);
        zero_trk = mean[SB-1:0];

        if (calibrating) begin
            win_samples = 0;
            level_acc   = '0;
            dev_sq_acc  = '0;
            calibrating = 1'b0;
            return 1'b0;
        end

        rms = floor_sqrt((dev_sq_acc << SQ_FRAC) / 64'(win_samples));
        mv  = (rms * 64'(gain_q) + (64'd1 << (MV_SHIFT - 1))) >> MV_SHIFT;
        if (mv >= 64'(MV_MAX)) begin
            mv      = 64'(MV_MAX);
            grp_sat = 1'b1;
        end
        mv_acc = mv_acc + mv;
        grp_windows++;

        win_samples = 0;
        level_acc   = '0;
        dev_sq_acc  = '0;

        if (grp_windows < navg) return 1'b0;

        // rounded group mean, half up
        avg = (mv_acc + 64'(grp_windows / 2)) / 64'(grp_windows);
        if (avg > 64'(MV_MAX)) avg = 64'(MV_MAX);
        rd.mv   = avg[MV_W-1:0];
        rd.zero = zero_trk;
        rd.sat  = grp_sat;

        grp_windows = 0;
        mv_acc      = '0;
        grp_sat     = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // sample driver: new payload only after a transfer or while valid is low
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic          nxt_valid;
        logic [SB-1:0] nxt_sample;
        nxt_valid  = i_sample_valid;
        nxt_sample = i_sample;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_sample_valid || sample_taken) begin
            nxt_valid = 1'b0;
            if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt_valid  = 1'b1;
                nxt_sample = sample_backlog.pop_front();
            end
        end
        i_sample_valid <= nxt_valid;
        i_sample       <= nxt_sample;
    end

    // result receiver: ready drawn afresh every cycle
    always @(negedge i_clk) begin
        i_result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: register mirror, sample transfers into the predictor,
    // reading transfers against the oldest owed reading
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reading want;
        t_reading owed;
        sample_taken <= i_rst_n && i_sample_valid && o_sample_ready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_LEN:  win_len_q = i_cfg_data[CFG_LEN_W-1:0];
                    CFG_AVG_WINDOWS: avg_win_q = i_cfg_data[CFG_AVG_W-1:0];
                    CFG_MAINS_SCALE: gain_q    = i_cfg_data[CFG_SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (o_result_valid && i_result_ready) begin
                if (pending_readings.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected reading: mv=%0d zero=%0d sat=%0b",
                                 o_voltage_mv, o_zero_level, o_saturated);
                end else begin
                    want = pending_readings.pop_front();
                    if (o_voltage_mv !== want.mv || o_zero_level !== want.zero
                        || o_saturated !== want.sat) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("reading mismatch: exp mv=%0d zero=%0d sat=%0b, got mv=%0d zero=%0d sat=%0b",
                                     want.mv, want.zero, want.sat,
                                     o_voltage_mv, o_zero_level, o_saturated);
                    end
                end
            end

            if (i_sample_valid && o_sample_ready) begin
                if (predict_meter_sample(i_sample, owed))
                    pending_readings.push_back(owed);
            end
        end
    end

    // watchdog: any transfer or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_sample_valid && o_sample_ready)
            || (o_result_valid && i_result_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly mains-like samples round mid-scale, some full range, some rails
    function automatic logic [SB-1:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0:       v = $urandom_range(1) ? (1 << SB) - 1 : 0;
            1, 2:    v = $urandom_range((1 << SB) - 1);
            default: v = 2048 + int'($urandom_range(1600)) - 800;
        endcase
        return v[SB-1:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // wait for every transfer and owed reading, then let window-end maths finish
    task automatic wait_quiet();
        while (sample_backlog.size() != 0 || i_sample_valid || pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // queue pushes happen on the rising edge, away from the driver
    task automatic start_phase(input int send_pct, input int recv_pct, input int n_items);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n_items) sample_backlog.push_back(pick_sample());
    endtask

    // directed windows of four: zero calibration that must repeat, calibration
    // at full scale, a window of the largest deviation, a mid-scale calibration,
    // then deviations on both sides of the zero level
    logic [SB-1:0] directed_samples [20] = '{
        12'd0,    12'd0,    12'd0,    12'd0,
        12'd4095, 12'd4095, 12'd4095, 12'd4095,
        12'd0,    12'd0,    12'd0,    12'd0,
        12'd2048, 12'd2048, 12'd2049, 12'd2047,
        12'd4095, 12'd0,    12'd2048, 12'd2049
    };

    // ------------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        meter_reset();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, short windows, no idling
        write_reg(CFG_WINDOW_LEN,  24'd4);
        write_reg(CFG_AVG_WINDOWS, 24'd1);
        write_reg(CFG_MAINS_SCALE, 24'd65536);
        start_phase(0, 0, 0);
        foreach (directed_samples[k]) sample_backlog.push_back(directed_samples[k]);
        wait_quiet();

        // zero length and zero count act as one, largest gain
        write_reg(CFG_WINDOW_LEN,  24'd0);
        write_reg(CFG_AVG_WINDOWS, 24'd0);
        write_reg(CFG_MAINS_SCALE, 24'hFF_FFFF);
        start_phase(0, 0, 24);
        wait_quiet();

        // short windows in groups of three, sparse sender
        write_reg(CFG_SPARE_IDX,   24'($urandom()));
        write_reg(CFG_WINDOW_LEN,  24'd5);
        write_reg(CFG_AVG_WINDOWS, 24'd3);
        write_reg(CFG_MAINS_SCALE, 24'($urandom()));
        start_phase(86, 0, 45);
        wait_quiet();

        // one reading per sample, zero gain, receiver mostly stalling
        write_reg(CFG_WINDOW_LEN,  24'd1);
        write_reg(CFG_AVG_WINDOWS, 24'd1);
        write_reg(CFG_MAINS_SCALE, 24'd0);
        start_phase(0, 86, 32);
        wait_quiet();

        // oversize length clamps to the longest window, which stays open here;
        // junk in the upper data bits
        write_reg(CFG_WINDOW_LEN,  {11'h5A5, 13'h1FFF});
        write_reg(CFG_MAINS_SCALE, 24'h01_2345);
        start_phase(0, 0, 24);
        wait_quiet();

        // one sample per window closes the open long window at once, then the
        // largest group with both sides idling; leaves a part-filled group behind
        write_reg(CFG_WINDOW_LEN,  24'd1);
        write_reg(CFG_AVG_WINDOWS, {16'hA5A5, 8'd255});
        write_reg(CFG_MAINS_SCALE, 24'h10_0000);
        start_phase(31, 31, 258);
        wait_quiet();

        // smaller count mid-group closes the leftover group on its next window
        write_reg(CFG_WINDOW_LEN,  24'd3);
        write_reg(CFG_AVG_WINDOWS, 24'd2);
        write_reg(CFG_MAINS_SCALE, 24'($urandom()));
        start_phase(31, 31, 30);
        wait_quiet();

        // stop part way through a long window ...
        write_reg(CFG_WINDOW_LEN,  24'd7);
        write_reg(CFG_AVG_WINDOWS, 24'd1);
        write_reg(CFG_MAINS_SCALE, 24'd65536);
        start_phase(86, 0, 12);
        wait_quiet();

        // ... then shorten it, so the open window ends on the next sample
        write_reg(CFG_WINDOW_LEN,  24'd2);
        write_reg(CFG_MAINS_SCALE, 24'($urandom()));
        start_phase(0, 86, 24);
        wait_quiet();

        if (fail_count == 0 && pending_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/trm_pkg.sv
rtl/trm_div.sv
rtl/trm_sqrt.sv
rtl/trm_dp.sv
rtl/trm_ctrl.sv
rtl/windowed_true_rms_meter_top.sv
dv/windowed_true_rms_meter_top_tb.sv
